// File: rtl/core/conv3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared types and constants of the streaming 3x3 neighbourhood filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

  // default size limits of the line stores and the row counter
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned WROW_W  = 3 * COEF_W;
  localparam int unsigned PROD_W  = COEF_W + PIX_W + 1;
  localparam int unsigned RSUM_W  = PROD_W + 2;
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned OPC_W   = 2 * DIM_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = WROW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_BOTTOM = 3'd4;

  localparam int unsigned RST_IMAGE_WIDTH  = 640;
  localparam int unsigned RST_IMAGE_HEIGHT = 480;

  // input word
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
    logic             flush;
  } pix_t;

  // result word
  typedef struct packed {
    logic signed [SUM_W-1:0] filtered;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    frame_last;
  } res_t;

  // position tag that travels with a result through the pipeline
  typedef struct packed {
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

  // accepted word as handed to the window stage
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fs;
    logic             vu;
    logic             vl;
    logic             vc;
    logic             res;
    tag_t             tag;
  } item_t;

  // 3x3 neighbourhood, [row][col]
  typedef logic [2:0][2:0][PIX_W-1:0] taps_t;

  // three kernel rows, each three packed coefficients
  typedef logic [2:0][WROW_W-1:0] wrows_t;

endpackage

// File: rtl/core/conv3_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3_stream_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface conv3_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/core/conv3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3_window
// Two line stores and the 3x3 window register; gives the padded taps.
// ----------------------------------------------------------------------------
module conv3_window import conv3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  item_t                        item_i,
  output logic                         s1_rdy_o,
  output logic                         tap_vld_o,
  output taps_t                        taps_o,
  output tag_t                         tag_o,
  input  logic                         tap_rdy_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic             s1_vld_q;
  item_t            s1_item_q;
  logic [AW-1:0]    s1_addr_q;

  logic [PIX_W-1:0] mem_u [MAX_WIDTH];
  logic [PIX_W-1:0] mem_l [MAX_WIDTH];
  logic [PIX_W-1:0] raw_u_q, raw_l_q;
  logic [PIX_W-1:0] byp_u_q, byp_l_q;
  logic             byp_sel_q;
  logic [PIX_W-1:0] rd_u, rd_l;

  taps_t            win_q, win_d, win_base, taps;
  logic [2:0][PIX_W-1:0] col_new;
  logic             s1_adv, s1_hit;

  // stage handshake: words without a result never wait on the multiplier
  assign s1_adv    = s1_vld_q && (!s1_item_q.res || tap_rdy_i);
  assign s1_rdy_o  = !s1_vld_q || s1_adv;
  assign s1_hit    = s1_adv && (s1_addr_q == addr_i);
  assign tap_vld_o = s1_vld_q && s1_item_q.res;
  assign taps_o    = taps;
  assign tag_o     = s1_item_q.tag;

  // read data, forwarded when the previous word writes the same column
  assign rd_u = byp_sel_q ? byp_u_q : raw_u_q;
  assign rd_l = byp_sel_q ? byp_l_q : raw_l_q;

  // upper line store: takes the old lower row
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_u[s1_addr_q] <= rd_l;
    end
    if (acc_i) begin
      raw_u_q <= mem_u[addr_i];
    end
  end

  // lower line store: takes the incoming pixel
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_l[s1_addr_q] <= s1_item_q.pix;
    end
    if (acc_i) begin
      raw_l_q <= mem_l[addr_i];
    end
  end

  // new column and window shift, padding at both ends of a row
  always_comb begin
    col_new[0] = s1_item_q.vu ? rd_u : '0;
    col_new[1] = s1_item_q.vl ? rd_l : '0;
    col_new[2] = s1_item_q.vc ? s1_item_q.pix : '0;
    win_base   = s1_item_q.fs ? '0 : win_q;
    for (int r = 0; r < 3; r++) begin
      if (s1_addr_q == '0) begin
        taps[r][0]  = win_base[r][1];
        taps[r][1]  = win_base[r][2];
        taps[r][2]  = '0;
        win_d[r][0] = '0;
        win_d[r][1] = '0;
        win_d[r][2] = col_new[r];
      end else begin
        win_d[r][0] = win_base[r][1];
        win_d[r][1] = win_base[r][2];
        win_d[r][2] = col_new[r];
        taps[r]     = win_d[r];
      end
    end
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      win_q    <= '0;
    end else begin
      if (acc_i) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q <= win_d;
      end
    end
  end

  // stage payload and forwarding data
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_item_q <= item_i;
      s1_addr_q <= addr_i;
      byp_sel_q <= s1_hit;
      byp_u_q   <= rd_l;
      byp_l_q   <= s1_item_q.pix;
    end
  end

  // a new word only enters when the stage is empty or moving on
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> (!s1_vld_q || s1_adv))
    else $error("window stage overwritten");

endmodule

// File: rtl/core/conv3_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3_mac
// Nine products, row sums and the final sum, with the output register.
// ----------------------------------------------------------------------------
module conv3_mac import conv3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   tap_vld_i,
  input  taps_t  taps_i,
  input  tag_t   tag_i,
  input  wrows_t wrows_i,
  output logic   tap_rdy_o,
  output logic   res_vld_o,
  output res_t   res_o,
  input  logic   res_rdy_i
);

  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [RSUM_W-1:0] rsum_d [3];
  logic signed [RSUM_W-1:0] rsum_q [3];
  logic signed [SUM_W-1:0]  sum_d;
  tag_t p_tag_q, r_tag_q;
  res_t out_q;
  logic p_vld_q, r_vld_q, o_vld_q;
  logic p_rdy, r_rdy, o_rdy;

  // stage handshakes
  assign o_rdy     = !o_vld_q || res_rdy_i;
  assign r_rdy     = !r_vld_q || o_rdy;
  assign p_rdy     = !p_vld_q || r_rdy;
  assign tap_rdy_o = p_rdy;
  assign res_vld_o = o_vld_q;
  assign res_o     = out_q;

  // signed coefficient times unsigned pixel
  always_comb begin
    logic signed [COEF_W-1:0] coef;
    coef = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef         = $signed(wrows_i[r][COEF_W*c +: COEF_W]);
        prod_d[r][c] = coef * $signed({1'b0, taps_i[r][c]});
      end
    end
  end

  // per-row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_d[r] = RSUM_W'(prod_q[r][0]) + RSUM_W'(prod_q[r][1])
                + RSUM_W'(prod_q[r][2]);
    end
  end

  assign sum_d = SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (p_rdy) begin
        p_vld_q <= tap_vld_i;
      end
      if (r_rdy) begin
        r_vld_q <= p_vld_q;
      end
      if (o_rdy) begin
        o_vld_q <= r_vld_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (p_rdy && tap_vld_i) begin
      prod_q  <= prod_d;
      p_tag_q <= tag_i;
    end
    if (r_rdy && p_vld_q) begin
      rsum_q  <= rsum_d;
      r_tag_q <= p_tag_q;
    end
    if (o_rdy && r_vld_q) begin
      out_q.filtered   <= sum_d;
      out_q.out_row    <= r_tag_q.row;
      out_q.out_col    <= r_tag_q.col;
      out_q.frame_last <= r_tag_q.last;
    end
  end

  // a row sum moving on always lands in the output register
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_vld_q && o_rdy |=> o_vld_q)
    else $error("result lost between row sum and output");

endmodule

// File: rtl/core/conv3x3_zero_padded_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_stream
// Streaming 3x3 weighted neighbourhood sum over a zero-padded grey image.
// ----------------------------------------------------------------------------
// Usage
//   pix_in carries one pixel word per handshake in raster order; frame_start
//   marks the first pixel of a frame, flush words carry no pixel and drain
//   the last row (W+1 of them after the final pixel).
//   res_out carries one result word per image pixel: the exact signed sum
//   of weight * pixel (Q4.12 weights give Q16.12), its row and column, and
//   frame_last on the final pixel of the frame.
//   The result of a pixel belongs to the input word W+1 places later; it
//   passes the window, product, row sum and output registers once that
//   word is accepted. One word per cycle is taken and given unless stalled.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   no word is in flight. A width write starts a restoring division that
//   re-derives the output row and column; pix_in.ready is low meanwhile.
//   Reset sets W=640, H=480, all weights to zero and clears the counters
//   and window; the line stores are not cleared.
//   A stalled receiver holds the output register; the three pipeline
//   registers behind it fill, then pix_in.ready drops.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_stream import conv3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  conv3_stream_if.sink          pix_in,
  conv3_stream_if.source        res_out
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned POS_W  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned DIM_MX = 2**DIM_W - 1;
  localparam int unsigned W_LIM  = (MAX_WIDTH < DIM_MX) ? MAX_WIDTH : DIM_MX;
  localparam int unsigned H_LIM  = (MAX_HEIGHT < DIM_MX) ? MAX_HEIGHT : DIM_MX;
  localparam int unsigned CMP_W0 = (POS_W > RW) ? POS_W : RW;
  localparam int unsigned CMP_W  = ((CMP_W0 > DIM_W) ? CMP_W0 : DIM_W) + 1;
  localparam int unsigned CNT_W  = $clog2(OPC_W + 1);

  // configuration registers
  logic [DIM_W-1:0] width_q, height_q;
  wrows_t           wrows_q;
  logic [DIM_W-1:0] w, h;
  logic [OPC_W-1:0] wh;

  // position counters
  logic [AW-1:0]    in_col_q;
  logic [RW-1:0]    in_row_q;
  logic [POS_W-1:0] in_pos_q;
  logic [OPC_W-1:0] opc_q;
  logic [ROW_W-1:0] orow_q;
  logic [DIM_W-1:0] ocol_q;

  // divider for a width change
  logic             div_busy_q;
  logic [CNT_W-1:0] div_cnt_q;
  logic [DIM_W-1:0] div_rem_q, div_rem_nx;
  logic [OPC_W-1:0] div_num_q, div_num_nx;
  logic [DIM_W:0]   div_trial, div_diff;
  logic             div_ge, div_start;

  // front stage
  pix_t             pix_w;
  logic             acc, s1_rdy, fs;
  logic [AW-1:0]    col0, col_nx;
  logic [RW-1:0]    row0, row_nx;
  logic [POS_W-1:0] pos0, pos_nx;
  logic [OPC_W-1:0] opc0, opc_nx;
  logic [ROW_W-1:0] orow0, orow_nx;
  logic [DIM_W-1:0] ocol0, ocol_nx;
  logic [CMP_W-1:0] row_x, h_x, col_inc;
  logic [DIM_W:0]   ocol_inc;
  logic             col_wrap, ocol_wrap;
  item_t            item;

  // window to multiplier
  logic  tap_vld, tap_rdy;
  taps_t taps;
  tag_t  tag;
  res_t  res_w;
  logic  res_vld;

  assign pix_w        = pix_in.data;
  assign acc          = pix_in.valid && pix_in.ready;
  assign pix_in.ready = !div_busy_q && s1_rdy;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(RST_IMAGE_WIDTH);
      height_q <= DIM_W'(RST_IMAGE_HEIGHT);
      wrows_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:    width_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q   <= cfg_wdata_i[DIM_W-1:0];
        CFG_WEIGHTS_TOP:    wrows_q[0] <= cfg_wdata_i;
        CFG_WEIGHTS_MIDDLE: wrows_q[1] <= cfg_wdata_i;
        CFG_WEIGHTS_BOTTOM: wrows_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped image size
  always_comb begin
    priority if (width_q == '0) begin
      w = DIM_W'(1);
    end else if (width_q > DIM_W'(W_LIM)) begin
      w = DIM_W'(W_LIM);
    end else begin
      w = width_q;
    end
    priority if (height_q == '0) begin
      h = DIM_W'(1);
    end else if (height_q > DIM_W'(H_LIM)) begin
      h = DIM_W'(H_LIM);
    end else begin
      h = height_q;
    end
  end

  assign wh = OPC_W'(w) * OPC_W'(h);

  // counters as seen by this word, frame start clears them first
  always_comb begin
    fs    = pix_w.frame_start;
    col0  = fs ? '0 : in_col_q;
    row0  = fs ? '0 : in_row_q;
    pos0  = fs ? '0 : in_pos_q;
    opc0  = fs ? '0 : opc_q;
    orow0 = fs ? '0 : orow_q;
    ocol0 = fs ? '0 : ocol_q;

    row_x = CMP_W'(row0);
    h_x   = CMP_W'(h);

    item.pix      = pix_w.flush ? '0 : pix_w.pixel;
    item.fs       = fs;
    item.vu       = (row_x >= CMP_W'(2)) && (row_x < h_x + CMP_W'(2));
    item.vl       = (row_x >= CMP_W'(1)) && (row_x < h_x + CMP_W'(1));
    item.vc       = row_x < h_x;
    item.res      = (CMP_W'(pos0) >= CMP_W'(w) + CMP_W'(1)) && (opc0 < wh);
    item.tag.row  = orow0;
    item.tag.col  = ocol0[COL_W-1:0];
    item.tag.last = opc0 == wh - OPC_W'(1);
  end

  // next counter values
  always_comb begin
    col_inc  = CMP_W'(col0) + CMP_W'(1);
    col_wrap = col_inc >= CMP_W'(w);
    col_nx   = col_wrap ? '0 : col_inc[AW-1:0];
    row_nx   = (col_wrap && (row0 < RW'(MAX_HEIGHT + 2))) ? row0 + RW'(1) : row0;
    pos_nx   = (pos0 < POS_W'(MAX_WIDTH + 1)) ? pos0 + POS_W'(1) : pos0;
    opc_nx   = item.res ? opc0 + OPC_W'(1) : opc0;

    ocol_inc  = {1'b0, ocol0} + (DIM_W+1)'(1);
    ocol_wrap = ocol_inc >= {1'b0, w};
    if (item.res) begin
      ocol_nx = ocol_wrap ? '0 : ocol_inc[DIM_W-1:0];
      orow_nx = ocol_wrap ? orow0 + ROW_W'(1) : orow0;
    end else begin
      ocol_nx = ocol0;
      orow_nx = orow0;
    end
  end

  // one restoring division step per cycle
  always_comb begin
    div_start  = cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH);
    div_trial  = {div_rem_q, div_num_q[OPC_W-1]};
    div_diff   = div_trial - {1'b0, w};
    div_ge     = div_trial >= {1'b0, w};
    div_rem_nx = div_ge ? div_diff[DIM_W-1:0] : div_trial[DIM_W-1:0];
    div_num_nx = {div_num_q[OPC_W-2:0], div_ge};
  end

  // counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_pos_q   <= '0;
      opc_q      <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= CNT_W'(OPC_W);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - CNT_W'(1);
        if (div_cnt_q == CNT_W'(1)) begin
          div_busy_q <= 1'b0;
        end
      end
      if (acc) begin
        in_col_q <= col_nx;
        in_row_q <= row_nx;
        in_pos_q <= pos_nx;
        opc_q    <= opc_nx;
      end
      priority if (div_busy_q && (div_cnt_q == CNT_W'(1))) begin
        orow_q <= div_num_nx[ROW_W-1:0];
        ocol_q <= div_rem_nx;
      end else if (acc) begin
        orow_q <= orow_nx;
        ocol_q <= ocol_nx;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_num_q <= opc_q;
    end else if (div_busy_q) begin
      div_rem_q <= div_rem_nx;
      div_num_q <= div_num_nx;
    end
  end

  // line stores and window
  conv3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .addr_i    (col0),
    .item_i    (item),
    .s1_rdy_o  (s1_rdy),
    .tap_vld_o (tap_vld),
    .taps_o    (taps),
    .tag_o     (tag),
    .tap_rdy_i (tap_rdy)
  );

  // weighted sum
  conv3_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tap_vld_i (tap_vld),
    .taps_i    (taps),
    .tag_i     (tag),
    .wrows_i   (wrows_q),
    .tap_rdy_o (tap_rdy),
    .res_vld_o (res_vld),
    .res_o     (res_w),
    .res_rdy_i (res_out.ready)
  );

  assign res_out.valid = res_vld;
  assign res_out.data  = res_w;

  // frame start restarts the lag count
  a_fs_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && pix_w.frame_start |=> in_pos_q == POS_W'(1))
    else $error("input position not restarted by frame start");

  // output column stays inside the row once the divider is done
  a_ocol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_busy_q |-> ocol_q < w)
    else $error("output column beyond image width");

  // no word is taken while the divider rebuilds the position
  a_div_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_busy_q) |-> !acc)
    else $error("word accepted while position is recomputed");

endmodule

// File: verif/conv3_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3_result_checker
// Watches the configuration port and both streams of the 3x3 filter, keeps
// its own copy of the line stores, window and position counters, works out
// the weighted neighbourhood sum each accepted pixel word releases, and
// compares every result word field by field with the oldest sum still due.
// ----------------------------------------------------------------------------
module conv3_result_checker import conv3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  pix_t                  pix_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  res_t                  res_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAX_REPORTS = 10;

  // shadow of the configuration registers
  bit [DIM_W-1:0]  width_reg;
  bit [DIM_W-1:0]  height_reg;
  bit [WROW_W-1:0] kernel_rows [3];

  // shadow of the neighbourhood state
  bit [PIX_W-1:0]  upper_line [MAX_WIDTH];
  bit [PIX_W-1:0]  lower_line [MAX_WIDTH];
  bit [PIX_W-1:0]  window [3][3];
  int unsigned     row_count;
  int unsigned     col_count;
  int unsigned     pos_count;
  int unsigned     out_count;

  res_t            sums_due [$];
  int unsigned     fails;

  function automatic int unsigned clamp_dim(input bit [DIM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // row index is offset by two so rows above the image stay unsigned
  function automatic bit row_inside(input int unsigned row_plus2, input int unsigned h);
    return row_plus2 >= 2 && row_plus2 - 2 < h;
  endfunction

  function automatic void clear_position();
    row_count = 0;
    col_count = 0;
    pos_count = 0;
    out_count = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) window[r][c] = '0;
    end
  endfunction

  // one pixel word in, at most one neighbourhood sum queued
  function automatic void predict_sum(input pix_t word);
    int unsigned              wd;
    int unsigned              ht;
    int unsigned              ic;
    int unsigned              ir;
    int unsigned              o;
    bit [PIX_W-1:0]           v;
    bit [PIX_W-1:0]           fresh [3];
    bit [PIX_W-1:0]           taps [3][3];
    logic signed [COEF_W-1:0] coef;
    longint                   acc;
    res_t                     want;
    wd = clamp_dim(width_reg, MAX_WIDTH);
    ht = clamp_dim(height_reg, MAX_HEIGHT);
    v  = word.flush ? '0 : word.pixel;
    if (word.frame_start) clear_position();
    ic = col_count % MAX_WIDTH;
    ir = row_count;

    // new column holds rows ir-2, ir-1 and ir, padding outside the image
    fresh[0] = row_inside(ir, ht) ? upper_line[ic] : '0;
    fresh[1] = row_inside(ir + 1, ht) ? lower_line[ic] : '0;
    fresh[2] = row_inside(ir + 2, ht) ? v : '0;
    upper_line[ic] = lower_line[ic];
    lower_line[ic] = v;

    // shift the window; at column 0 the centre was the end of a row
    for (int r = 0; r < 3; r++) begin
      if (ic == 0) begin
        taps[r][0]   = window[r][1];
        taps[r][1]   = window[r][2];
        taps[r][2]   = '0;
        window[r][0] = '0;
        window[r][1] = '0;
        window[r][2] = fresh[r];
      end else begin
        window[r][0] = window[r][1];
        window[r][1] = window[r][2];
        window[r][2] = fresh[r];
        for (int c = 0; c < 3; c++) taps[r][c] = window[r][c];
      end
    end

    // a sum is due once the lag is filled and until the frame is complete
    if (pos_count >= wd + 1 && out_count < wd * ht) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          coef = kernel_rows[r][COEF_W*c +: COEF_W];
          acc += longint'(coef) * longint'(taps[r][c]);
        end
      end
      o = out_count;
      want.filtered   = acc[SUM_W-1:0];
      want.out_row    = ROW_W'(o / wd);
      want.out_col    = COL_W'(o % wd);
      want.frame_last = (o == wd * ht - 1);
      sums_due.push_back(want);
      out_count = o + 1;
    end

    // position and row counters saturate rather than wrap
    if (pos_count != 32'hFFFF_FFFF) pos_count++;
    col_count++;
    if (col_count >= wd) begin
      col_count = 0;
      if (row_count < MAX_HEIGHT + 2) row_count++;
    end
  endfunction

  function automatic void check_result(input res_t got);
    res_t want;
    if (sums_due.size() == 0) begin
      fails++;
      if (fails <= MAX_REPORTS) begin
        $display("%0t: unexpected result word: sum %0d row %0d col %0d last %0b", $time,
                 got.filtered, got.out_row, got.out_col, got.frame_last);
      end
      return;
    end
    want = sums_due.pop_front();
    if (got.filtered !== want.filtered || got.out_row !== want.out_row ||
        got.out_col !== want.out_col || got.frame_last !== want.frame_last) begin
      fails++;
      if (fails <= MAX_REPORTS) begin
        $display("%0t: result mismatch: expected sum %0d row %0d col %0d last %0b", $time,
                 want.filtered, want.out_row, want.out_col, want.frame_last);
        $display("%0t:                  got      sum %0d row %0d col %0d last %0b", $time,
                 got.filtered, got.out_row, got.out_col, got.frame_last);
      end
    end
  endfunction

  // register writes, then pixel words, then result words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = DIM_W'(RST_IMAGE_WIDTH);
      height_reg = DIM_W'(RST_IMAGE_HEIGHT);
      for (int r = 0; r < 3; r++) kernel_rows[r] = '0;
      clear_position();
      sums_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:    width_reg      = cfg_wdata_i[DIM_W-1:0];
          CFG_IMAGE_HEIGHT:   height_reg     = cfg_wdata_i[DIM_W-1:0];
          CFG_WEIGHTS_TOP:    kernel_rows[0] = cfg_wdata_i;
          CFG_WEIGHTS_MIDDLE: kernel_rows[1] = cfg_wdata_i;
          CFG_WEIGHTS_BOTTOM: kernel_rows[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) predict_sum(pix_data_i);
      if (res_valid_i && res_ready_i) check_result(res_data_i);
      fail_count_o <= fails;
      pending_o    <= sums_due.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the 3x3 filter testbench: drives raster frames with flush tails,
// broken and noisy frames, size and kernel changes between frames, size
// changes mid-frame, random gaps on both streams and long receiver stalls;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import conv3_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1750;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned MAX_GAP       = 5;

  localparam logic [COEF_W-1:0] COEF_MIN  = 16'h8000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_ZERO = 16'h0000;

  // how one frame is sent
  typedef struct packed {
    bit noisy;        // stray flush words in the frame and pixels in the tail
    bit truncate;     // frame cut short, next frame_start takes over
    bit junk;         // extra words after the frame is complete
    bit extreme;      // pixels only 0 or 255
    bit start_flush;  // first word carries frame_start and flush
    bit pause;        // sender waits mid-frame until all sums are out
    bit hold;         // receiver holds off for a long stretch
    bit resize;       // width shrinks after two full rows
  } frame_opts_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           quiet_cycles;
  int unsigned           items_sent;
  int unsigned           cur_w;
  int unsigned           cur_h;
  logic [WROW_W-1:0]     kernel_now [3];
  bit                    src_calm;
  bit                    sink_calm;
  bit                    hold_req;

  conv3_stream_if #(.T(pix_t)) pix_if ();
  conv3_stream_if #(.T(res_t)) res_if ();

  conv3x3_zero_padded_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_in      (pix_if),
    .res_out     (res_if)
  );

  conv3_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pix_valid_i  (pix_if.valid),
    .pix_ready_i  (pix_if.ready),
    .pix_data_i   (pix_if.data),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_data_i   (res_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver: random stalls, calm stretches, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    res_if.ready = 1'b0;
    sink_calm    = 1'b0;
    taken        = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      @(negedge clk_i);
      taken++;
      if (taken % 64 == 0) sink_calm = ($urandom_range(0, 2) == 0);
    end
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // kernel row, optionally with coefficients pinned to the extremes
  function automatic logic [WROW_W-1:0] draw_kernel_row(input bit edgy);
    logic [WROW_W-1:0] row;
    row = WROW_W'({$urandom(), $urandom()});
    if (edgy) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 3))
          0: row[COEF_W*c +: COEF_W] = COEF_MIN;
          1: row[COEF_W*c +: COEF_W] = COEF_MAX;
          2: row[COEF_W*c +: COEF_W] = COEF_ZERO;
          default: ;
        endcase
      end
    end
    return row;
  endfunction

  // one pixel word, called and returning at a falling edge
  task automatic send_word(input logic [PIX_W-1:0] px, input logic fs, input logic fl);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= '{pixel: px, frame_start: fs, flush: fl};
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // stop sending and wait until the block has nothing left in flight
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // width goes last so its division runs on the final settings
  task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [WROW_W-1:0] top, input logic [WROW_W-1:0] mid,
                            input logic [WROW_W-1:0] bot);
    logic [CFG_IDX_W-1:0]  order [5];
    logic [CFG_DATA_W-1:0] value [5];
    order = '{CFG_IMAGE_HEIGHT, CFG_WEIGHTS_TOP, CFG_WEIGHTS_MIDDLE, CFG_WEIGHTS_BOTTOM,
              CFG_IMAGE_WIDTH};
    value = '{CFG_DATA_W'(h), top, mid, bot, CFG_DATA_W'(w)};
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= order[i];
      cfg_wdata <= value[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    cur_w  = eff_dim(w, DEF_MAX_WIDTH);
    cur_h  = eff_dim(h, DEF_MAX_HEIGHT);
    kernel_now[0] = top;
    kernel_now[1] = mid;
    kernel_now[2] = bot;
  endtask

  // one frame: W*H pixels then W+1 drain words, shaped by the options
  task automatic send_frame(input frame_opts_t opt);
    int unsigned    n_pix;
    int unsigned    stop_at;
    int unsigned    event_at;
    bit             resized;
    logic [PIX_W-1:0] px;
    logic           fl;
    n_pix    = cur_w * cur_h;
    stop_at  = opt.truncate ? $urandom_range(1, n_pix + cur_w) : n_pix + cur_w + 1;
    event_at = $urandom_range(0, n_pix / 2);
    resized  = 1'b0;
    for (int unsigned k = 0; k < n_pix + cur_w + 1 && k < stop_at; k++) begin
      if (opt.pause && k == event_at) settle();
      if (opt.hold && k == event_at) hold_req = 1'b1;
      if (opt.resize && !resized && cur_w > 1 && k == 2 * cur_w) begin
        resized = 1'b1;
        set_config(DIM_W'($urandom_range(1, cur_w - 1)), DIM_W'($urandom_range(1, 8)),
                   kernel_now[0], kernel_now[1], kernel_now[2]);
      end
      px = opt.extreme ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : PIX_W'($urandom());
      if (k >= n_pix) fl = opt.noisy ? ($urandom_range(0, 3) != 0) : 1'b1;
      else fl = opt.noisy && ($urandom_range(0, 15) == 0);
      if (k == 0 && opt.start_flush) fl = 1'b1;
      send_word(px, k == 0, fl);
    end
    if (opt.junk) begin
      repeat ($urandom_range(1, 4)) send_word(PIX_W'($urandom()), 1'b0, 1'($urandom()));
    end
  endtask

  initial begin : stimulus
    frame_opts_t opts;
    int unsigned n_frames;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    bit edgy;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    hold_req     = 1'b0;
    src_calm     = 1'b0;
    items_sent   = 0;
    cur_w        = RST_IMAGE_WIDTH;
    cur_h        = RST_IMAGE_HEIGHT;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every weight at its most negative, pixels 0 and 255, frame_start with flush
    set_config(DIM_W'(3), DIM_W'(3), {3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
    opts = '0;
    opts.extreme     = 1'b1;
    opts.start_flush = 1'b1;
    send_frame(opts);

    // every weight at its most positive, words after the frame is complete
    set_config(DIM_W'(3), DIM_W'(3), {3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
    opts = '0;
    opts.extreme = 1'b1;
    opts.junk    = 1'b1;
    send_frame(opts);

    // zero sizes clamp to a single pixel
    set_config(DIM_W'(0), DIM_W'(0), draw_kernel_row(1'b1), draw_kernel_row(1'b1),
               draw_kernel_row(1'b1));
    send_frame('0);

    // height above the limit with counters run to saturation, a sender pause
    // and a long receiver hold that fills the block
    set_config(DIM_W'(1), 11'h7FF, draw_kernel_row(1'b1), draw_kernel_row(1'b0),
               draw_kernel_row(1'b1));
    src_calm = 1'b0;
    opts = '0;
    opts.pause = 1'b1;
    opts.hold  = 1'b1;
    send_frame(opts);
    repeat (12) send_word(PIX_W'($urandom()), 1'b0, 1'($urandom()));

    // random frames, mostly well formed, small sizes
    n_frames = 0;
    while (items_sent < ITEM_TARGET) begin
      if (n_frames == 0 || $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0) w = '0;
        else if ($urandom_range(0, 9) == 0) w = DIM_W'($urandom_range(13, 48));
        else w = DIM_W'($urandom_range(1, 12));
        h    = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 8));
        edgy = ($urandom_range(0, 3) == 0);
        set_config(w, h, draw_kernel_row(edgy), draw_kernel_row(edgy), draw_kernel_row(edgy));
      end
      opts.noisy       = ($urandom_range(0, 3) == 0);
      opts.truncate    = ($urandom_range(0, 7) == 0);
      opts.junk        = ($urandom_range(0, 5) == 0);
      opts.extreme     = ($urandom_range(0, 5) == 0);
      opts.start_flush = ($urandom_range(0, 7) == 0);
      opts.pause       = (n_frames == 1) || ($urandom_range(0, 9) == 0);
      opts.hold        = (n_frames == 0) || ($urandom_range(0, 19) == 0);
      opts.resize      = ($urandom_range(0, 9) == 0);
      src_calm         = ($urandom_range(0, 4) == 0);
      send_frame(opts);
      n_frames++;
    end

    // drain, then verdict
    pix_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/conv3_pkg.sv
rtl/core/conv3_stream_if.sv
rtl/core/conv3_window.sv
rtl/core/conv3_mac.sv
rtl/core/conv3x3_zero_padded_stream.sv
verif/conv3_result_checker.sv
verif/tb.sv
